[rtl/huffman_stream_decoder_unit_macros.svh]
// Assertion macros for the checker file of the decoder.
`ifndef HUFFMAN_STREAM_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsd assertion failed");

// Next-cycle implication, checked out of reset.
`define HSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsd assertion failed");

`endif

[rtl/hsd_pkg.sv]
// ----------------------------------------------------------------------------
// hsd_pkg
// Types, sizes and codes shared by the Huffman stream decoder modules.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int MAX_LEAVES  = 256;
    localparam int STACK_DEPTH = 256;

    localparam int NODE_CAP = 2 * MAX_LEAVES - 1;
    localparam int NODE_W   = $clog2(NODE_CAP);        // node index
    localparam int NCNT_W   = $clog2(NODE_CAP + 1);    // node count
    localparam int SP_W     = $clog2(STACK_DEPTH + 1); // stack pointer
    localparam int STK_AW   = $clog2(STACK_DEPTH);     // stack memory address
    localparam int STK_W    = NODE_W + 1;              // node index + right-next flag
    localparam int ENT_W    = 9;                       // leaf flag + symbol

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_TREE       = 2'd1;
    localparam logic [1:0] ERR_AFTER_DONE = 2'd2;

    typedef enum logic [2:0] {
        PH_TREE,
        PH_COUNT,
        PH_DATA,
        PH_SINGLE,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef struct packed {
        logic start;      // capture item
        logic simple;     // one-shot work: count byte, pull, status
        logic tree;       // consume one header bit
        logic pop_load;   // reload top of stack from memory
        logic walk_issue; // pick child by code bit, read node memory
        logic walk_land;  // take child entry; on leaf hold symbol, emit held one
        logic finish;     // send last beat of the item
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   op;
        logic   tree_stop;
        logic   tree_pop;
        logic   out_free;
        logic   walk_more;
    } t_status;

endpackage

[rtl/hsd_ram.sv]
// ----------------------------------------------------------------------------
// hsd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hsd_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/hsd_ctrl.sv]
// ----------------------------------------------------------------------------
// hsd_ctrl
// Sequencer: walks each accepted item through the datapath, header and code bytes bit by bit.
// ----------------------------------------------------------------------------
module hsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  hsd_pkg::t_status i_status,
    output logic             o_in_ready,
    output hsd_pkg::t_cmd    o_cmd
);
    import hsd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TREE,
        S_POPW,
        S_WALK,
        S_LAND,
        S_FINISH
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_cnt = '0;
                if (!i_status.op && i_status.phase == PH_TREE) begin
                    n_state = S_TREE;
                end else if (!i_status.op && i_status.phase == PH_DATA) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.simple = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_TREE: begin
                o_cmd.tree = 1'b1;
                n_cnt      = r_cnt + 4'd1;
                if (i_status.tree_stop) begin
                    n_state = S_FINISH;
                end else if (i_status.tree_pop) begin
                    n_state = S_POPW;
                end else if (r_cnt == 4'd7) begin
                    n_state = S_FINISH;
                end
            end
            S_POPW: begin
                o_cmd.pop_load = 1'b1;
                n_state        = r_cnt[3] ? S_FINISH : S_TREE;
            end
            S_WALK: begin
                if (r_cnt[3] || !i_status.walk_more) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.walk_issue = 1'b1;
                    n_cnt            = r_cnt + 4'd1;
                    n_state          = S_LAND;
                end
            end
            S_LAND: begin
                if (i_status.out_free) begin
                    o_cmd.walk_land = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[rtl/hsd_datapath.sv]
// ----------------------------------------------------------------------------
// hsd_datapath
// Tree builder, count register, tree walker and result register.
// ----------------------------------------------------------------------------
module hsd_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hsd_pkg::t_cmd    i_cmd,
    input  logic             i_op,
    input  logic [7:0]       i_in_byte,
    input  logic             i_out_ready,
    output hsd_pkg::t_status o_status,
    output logic             o_out_valid,
    output logic [7:0]       o_sym,
    output logic             o_sym_valid,
    output logic             o_run_last,
    output logic             o_done_res,
    output logic [1:0]       o_error
);
    import hsd_pkg::*;

    t_phase            r_phase;
    logic              r_op;
    logic [7:0]        r_byte;
    logic [NCNT_W-1:0] r_node_count;
    logic [SP_W-1:0]   r_sp;
    logic [NODE_W-1:0] r_top_idx;
    logic              r_top_right;
    logic [3:0]        r_leaf_left;
    logic [7:0]        r_leaf_shift;
    logic [1:0]        r_cbi;
    logic [31:0]       r_bit_total;
    logic [31:0]       r_bits_used;
    logic [NODE_W-1:0] r_cur_l, r_cur_r;
    logic [NODE_W-1:0] r_root_l, r_root_r;
    logic              r_root_leaf;
    logic [7:0]        r_root_sym;
    logic              r_hold_valid;
    logic [7:0]        r_hold_sym;
    logic [1:0]        r_err;
    logic              r_out_valid;
    logic [7:0]        r_out_sym;
    logic              r_out_symv, r_out_last, r_out_done;
    logic [1:0]        r_out_err;

    // header bit decode
    logic              tb, do_place, place_int, overflow, placing, has_parent;
    logic              link_l, link_r, stack_full, push, leaf_done, pop_read, tree_err;
    logic [7:0]        t_sym;
    logic [3:0]        n_leaf_left;
    logic [7:0]        n_leaf_shift;
    logic [SP_W-1:0]   sp_after, sp_m1, sp_m2;
    logic [NODE_W-1:0] idx;

    always_comb begin
        tb           = r_byte[7];
        n_leaf_left  = r_leaf_left;
        n_leaf_shift = r_leaf_shift;
        do_place     = 1'b0;
        place_int    = 1'b0;
        t_sym        = '0;
        if (r_leaf_left != 4'd0) begin
            n_leaf_shift = {r_leaf_shift[6:0], tb};
            n_leaf_left  = r_leaf_left - 4'd1;
            if (r_leaf_left == 4'd1) begin
                do_place = 1'b1;
                t_sym    = n_leaf_shift;
            end
        end else if (tb) begin
            n_leaf_left  = 4'd8;
            n_leaf_shift = '0;
        end else begin
            do_place  = 1'b1;
            place_int = 1'b1;
        end
    end

    assign idx        = r_node_count[NODE_W-1:0];
    assign overflow   = do_place && (r_node_count >= NCNT_W'(NODE_CAP));
    assign placing    = do_place && !overflow;
    assign has_parent = (r_sp != '0);
    assign link_r     = placing && has_parent && r_top_right;
    assign link_l     = placing && has_parent && !r_top_right;
    assign sp_after   = r_sp - SP_W'(link_r);
    assign stack_full = placing && place_int && (sp_after >= SP_W'(STACK_DEPTH));
    assign push       = placing && place_int && !stack_full;
    assign leaf_done  = placing && !place_int && (sp_after == '0);
    assign pop_read   = placing && !place_int && link_r && (sp_after != '0);
    assign tree_err   = overflow || stack_full;
    assign sp_m1      = r_sp - SP_W'(1);
    assign sp_m2      = r_sp - SP_W'(2);

    // node memories: entry, left child, right child; stack below the top
    logic [NODE_W-1:0] walk_addr;
    logic [ENT_W-1:0]  ent_rdata;
    logic [NODE_W-1:0] left_rdata, right_rdata;
    logic [STK_W-1:0]  stk_rdata;

    assign walk_addr = r_byte[7] ? r_cur_r : r_cur_l;

    hsd_ram #(.WIDTH(ENT_W), .DEPTH(NODE_CAP)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tree && placing),
        .i_waddr (idx),
        .i_wdata ({!place_int, t_sym}),
        .i_re    (i_cmd.walk_issue),
        .i_raddr (walk_addr),
        .o_rdata (ent_rdata)
    );

    hsd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tree && link_l),
        .i_waddr (r_top_idx),
        .i_wdata (idx),
        .i_re    (i_cmd.walk_issue),
        .i_raddr (walk_addr),
        .o_rdata (left_rdata)
    );

    hsd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tree && link_r),
        .i_waddr (r_top_idx),
        .i_wdata (idx),
        .i_re    (i_cmd.walk_issue),
        .i_raddr (walk_addr),
        .o_rdata (right_rdata)
    );

    hsd_ram #(.WIDTH(STK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tree && push && has_parent && !link_r),
        .i_waddr (sp_m1[STK_AW-1:0]),
        .i_wdata ({r_top_idx, r_top_right | link_l}),
        .i_re    (i_cmd.tree),
        .i_raddr (sp_m2[STK_AW-1:0]),
        .o_rdata (stk_rdata)
    );

    // count byte merge and end-of-item phase
    logic [31:0] new_total;
    t_phase      fin_phase;
    logic        land_leaf, out_load;

    assign new_total = r_bit_total | (32'(r_byte) << {r_cbi, 3'b000});
    assign fin_phase = (r_phase == PH_DATA && r_bits_used >= r_bit_total) ? PH_DONE : r_phase;
    assign land_leaf = ent_rdata[ENT_W-1];
    assign out_load  = i_cmd.finish || (i_cmd.walk_land && land_leaf && r_hold_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TREE;
            r_node_count <= '0;
            r_sp         <= '0;
            r_top_right  <= 1'b0;
            r_leaf_left  <= '0;
            r_leaf_shift <= '0;
            r_cbi        <= '0;
            r_bit_total  <= '0;
            r_bits_used  <= '0;
            r_hold_valid <= 1'b0;
            r_err        <= ERR_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_op         <= i_op;
                r_byte       <= i_in_byte;
                r_hold_valid <= 1'b0;
                r_err        <= ERR_NONE;
            end

            if (i_cmd.simple) begin
                case (r_phase)
                    PH_DONE: r_err <= ERR_AFTER_DONE;
                    PH_ERR:  r_err <= ERR_TREE;
                    default: begin
                        if (r_op) begin
                            if (r_phase == PH_SINGLE && r_bits_used < r_bit_total) begin
                                r_hold_valid <= 1'b1;
                                r_hold_sym   <= r_root_sym;
                                r_bits_used  <= r_bits_used + 32'd1;
                                if ((r_bits_used + 32'd1) == r_bit_total) begin
                                    r_phase <= PH_DONE;
                                end
                            end
                        end else if (r_phase == PH_COUNT) begin
                            r_bit_total <= new_total;
                            r_cbi       <= r_cbi + 2'd1;
                            if (r_cbi == 2'd3) begin
                                r_bits_used <= '0;
                                r_cur_l     <= r_root_l;
                                r_cur_r     <= r_root_r;
                                if (new_total == 32'd0) begin
                                    r_phase <= PH_DONE;
                                end else if (r_root_leaf) begin
                                    r_phase <= PH_SINGLE;
                                end else begin
                                    r_phase <= PH_DATA;
                                end
                            end
                        end
                    end
                endcase
            end

            if (i_cmd.tree) begin
                r_byte       <= {r_byte[6:0], 1'b0};
                r_leaf_left  <= n_leaf_left;
                r_leaf_shift <= n_leaf_shift;
                if (placing) begin
                    r_node_count <= r_node_count + NCNT_W'(1);
                    if (idx == '0) begin
                        r_root_leaf <= !place_int;
                        r_root_sym  <= t_sym;
                    end
                end
                if (link_l) begin
                    r_top_right <= 1'b1;
                    if (r_top_idx == '0) begin
                        r_root_l <= idx;
                    end
                end
                if (link_r) begin
                    r_sp <= r_sp - SP_W'(1);
                    if (r_top_idx == '0) begin
                        r_root_r <= idx;
                    end
                end
                // a push after a pop only replaces the top
                if (push) begin
                    r_top_idx   <= idx;
                    r_top_right <= 1'b0;
                    r_sp        <= link_r ? r_sp : r_sp + SP_W'(1);
                end
                if (tree_err) begin
                    r_phase <= PH_ERR;
                    r_err   <= ERR_TREE;
                end else if (leaf_done) begin
                    r_phase <= PH_COUNT;
                end
            end

            if (i_cmd.pop_load) begin
                r_top_idx   <= stk_rdata[STK_W-1:1];
                r_top_right <= stk_rdata[0];
            end

            if (i_cmd.walk_issue) begin
                r_byte      <= {r_byte[6:0], 1'b0};
                r_bits_used <= r_bits_used + 32'd1;
            end

            if (i_cmd.walk_land) begin
                if (land_leaf) begin
                    r_hold_valid <= 1'b1;
                    r_hold_sym   <= ent_rdata[7:0];
                    r_cur_l      <= r_root_l;
                    r_cur_r      <= r_root_r;
                end else begin
                    r_cur_l <= left_rdata;
                    r_cur_r <= right_rdata;
                end
            end

            if (i_cmd.finish) begin
                r_phase <= fin_phase;
            end

            // result register: earlier symbol goes out as a non-last beat, the last beat carries the status
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (i_cmd.finish) begin
                    r_out_sym  <= r_hold_valid ? r_hold_sym : 8'd0;
                    r_out_symv <= r_hold_valid;
                    r_out_last <= 1'b1;
                    r_out_done <= (fin_phase == PH_DONE);
                    r_out_err  <= r_err;
                end else begin
                    r_out_sym  <= r_hold_sym;
                    r_out_symv <= 1'b1;
                    r_out_last <= 1'b0;
                    r_out_done <= 1'b0;
                    r_out_err  <= ERR_NONE;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.phase     = r_phase;
    assign o_status.op        = r_op;
    assign o_status.tree_stop = tree_err || leaf_done;
    assign o_status.tree_pop  = pop_read;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.walk_more = (r_bits_used < r_bit_total);

    assign o_out_valid = r_out_valid;
    assign o_sym       = r_out_sym;
    assign o_sym_valid = r_out_symv;
    assign o_run_last  = r_out_last;
    assign o_done_res  = r_out_done;
    assign o_error     = r_out_err;

endmodule

[rtl/huffman_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// huffman_stream_decoder_unit
// Byte-fed Huffman decoder with a pre-order tree header and a bit count.
// ----------------------------------------------------------------------------
// Feed the compressed file one byte per input beat (op 0), MSB first. The
// header builds the node table one bit per cycle, except that a pop that
// uncovers an older stack entry waits for the stack memory read. Header
// padding after the last leaf is dropped. Four count bytes then follow,
// little endian. In the data phase each code bit takes one node-memory read
// and one step to the child, and the walk waits while the output stalls.
// Each data byte returns one beat per decoded symbol (the last one carries the
// status) or a single status beat when no symbol ends in it. For a one-leaf
// tree send pull beats (op 1); each returns one copy of the symbol until the
// count is used up. A new beat is taken only after the previous one has been
// fully worked off; a one-deep result register sits on the output side.
// Errors: 1 when the tree overflows the node table or the pending stack, kept
// for every later beat; 2 for any beat after the count is exhausted.
module huffman_stream_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_sym,
    output logic       o_sym_valid,
    output logic       o_run_last,
    output logic       o_done_res,
    output logic [1:0] o_error
);
    import hsd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: at most one command per cycle
    hsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // tree build, count, walk and result register
    hsd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_op),
        .i_in_byte   (i_in_byte),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_sym       (o_sym),
        .o_sym_valid (o_sym_valid),
        .o_run_last  (o_run_last),
        .o_done_res  (o_done_res),
        .o_error     (o_error)
    );

endmodule

[rtl/hsd_checker.sv]
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks on the decoder input handshake and result stream.
// ----------------------------------------------------------------------------
`include "huffman_stream_decoder_unit_macros.svh"

module hsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_sym,
    input logic       o_sym_valid,
    input logic       o_run_last,
    input logic       o_done_res,
    input logic [1:0] o_error
);

    // one input beat in flight: drop ready right after an accept
    `HSD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready)
    // hold a stalled beat
    `HSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_sym) && $stable(o_run_last))
    // a beat without a symbol is always the status beat
    `HSD_ASSERT_NOW(a_status_last, i_clk, i_rst_n, o_out_valid && !o_sym_valid,
        o_run_last && o_sym == 8'd0)
    // status rides only on the last beat
    `HSD_ASSERT_NOW(a_status_on_last, i_clk, i_rst_n, o_out_valid && !o_run_last,
        o_error == 2'd0 && !o_done_res)
    // input after done reports done
    `HSD_ASSERT_NOW(a_after_done, i_clk, i_rst_n, o_out_valid && o_error == 2'd2,
        o_done_res && !o_sym_valid)

endmodule

bind huffman_stream_decoder_unit hsd_checker u_hsd_checker (.*);

[tb/sv/huffman_stream_decoder_unit_checker.sv]
// ----------------------------------------------------------------------------
// huffman_stream_decoder_unit_checker
// Watches both channels of the decoder, predicts the result beats of every
// accepted input beat and compares them field by field in order.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_unit_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_sym,
    input  logic       i_sym_valid,
    input  logic       i_run_last,
    input  logic       i_done_res,
    input  logic [1:0] i_error,
    output int         o_fail_count,
    output int         o_pending
);
    import hsd_pkg::*;

    localparam logic [18:0] LEAF_BIT = 19'h40000;

    typedef struct packed {
        logic [7:0] sym;
        logic       sym_valid;
        logic       run_last;
        logic       done_res;
        logic [1:0] error;
    } t_beat;

    t_beat       decoded_q[$];
    t_phase      phase;
    logic [18:0] node_tab[NODE_CAP];
    logic [9:0]  pend_stk[STACK_DEPTH];
    int          sp, nodes, leaf_left, cnt_idx;
    logic [7:0]  leaf_acc;
    logic [31:0] total_bits, used_bits;
    int          walk;
    int          fails;
    int          queued;

    assign o_fail_count = fails;
    assign o_pending    = queued;

    // 0 go on, 1 tree complete, 2 overflow
    function automatic int add_node(logic [18:0] ent, bit internal);
        int idx, top, parent;
        if (nodes >= NODE_CAP) return 2;
        idx = nodes;
        nodes++;
        node_tab[idx] = ent;
        if (sp > 0) begin
            top    = pend_stk[sp-1];
            parent = (top >> 1) % NODE_CAP;
            if (top & 1) begin
                node_tab[parent] = node_tab[parent] | 19'(idx);
                sp--;
            end else begin
                node_tab[parent] = node_tab[parent] | (19'(idx) << 9);
                pend_stk[sp-1] = 10'(top | 1);
            end
        end
        if (internal) begin
            if (sp >= STACK_DEPTH) return 2;
            pend_stk[sp] = 10'(idx << 1);
            sp++;
            return 0;
        end
        return (sp == 0) ? 1 : 0;
    endfunction

    function automatic int header_bit(logic b);
        if (leaf_left > 0) begin
            leaf_acc = {leaf_acc[6:0], b};
            leaf_left--;
            if (leaf_left > 0) return 0;
            return add_node(LEAF_BIT | 19'(leaf_acc), 1'b0);
        end
        if (b) begin
            leaf_left = 8;
            leaf_acc  = '0;
            return 0;
        end
        return add_node('0, 1'b1);
    endfunction

    // Work out the result beats of one input beat and queue them.
    task automatic decode_beat(logic op, logic [7:0] byte_in);
        logic [7:0]  syms[$];
        logic [1:0]  err;
        logic [18:0] ent;
        int          r, child;
        t_beat       b;
        err = ERR_NONE;
        if (phase == PH_DONE) begin
            err = ERR_AFTER_DONE;
        end else if (phase == PH_ERR) begin
            err = ERR_TREE;
        end else if (op) begin
            if (phase == PH_SINGLE && used_bits < total_bits) begin
                syms.push_back(node_tab[0][7:0]);
                used_bits++;
                if (used_bits == total_bits) phase = PH_DONE;
            end
        end else if (phase == PH_TREE) begin
            for (int i = 7; i >= 0; i--) begin
                r = header_bit(byte_in[i]);
                if (r == 2) begin
                    phase = PH_ERR;
                    err   = ERR_TREE;
                    break;
                end
                if (r == 1) begin
                    phase = PH_COUNT;
                    break;
                end
            end
        end else if (phase == PH_COUNT) begin
            total_bits = total_bits | (32'(byte_in) << (8 * cnt_idx));
            cnt_idx    = (cnt_idx + 1) & 3;
            if (cnt_idx == 0) begin
                used_bits = 0;
                walk      = 0;
                if (total_bits == 0) phase = PH_DONE;
                else phase = node_tab[0][18] ? PH_SINGLE : PH_DATA;
            end
        end else if (phase == PH_DATA) begin
            for (int i = 7; i >= 0 && used_bits < total_bits; i--) begin
                ent   = node_tab[walk % NODE_CAP];
                child = byte_in[i] ? ent[8:0] : ent[17:9];
                child = child % NODE_CAP;
                used_bits++;
                if (node_tab[child][18]) begin
                    syms.push_back(node_tab[child][7:0]);
                    walk = 0;
                end else begin
                    walk = child;
                end
            end
            if (used_bits >= total_bits) phase = PH_DONE;
        end
        if (syms.size() == 0) begin
            b = '0;
            b.run_last = 1'b1;
            b.done_res = (phase == PH_DONE);
            b.error    = err;
            decoded_q.push_back(b);
        end else begin
            foreach (syms[k]) begin
                b = '0;
                b.sym       = syms[k];
                b.sym_valid = 1'b1;
                if (k == syms.size() - 1) begin
                    b.run_last = 1'b1;
                    b.done_res = (phase == PH_DONE);
                    b.error    = err;
                end
                decoded_q.push_back(b);
            end
        end
    endtask

    initial begin
        phase = PH_TREE;
        foreach (node_tab[i]) node_tab[i] = '0;
        sp = 0; nodes = 0; leaf_left = 0; leaf_acc = '0; cnt_idx = 0;
        total_bits = '0; used_bits = '0; walk = 0; fails = 0; queued = 0;
    end

    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) decode_beat(i_op, i_in_byte);
            if (i_out_valid && i_out_ready) begin
                got = {i_sym, i_sym_valid, i_run_last, i_done_res, i_error};
                if (decoded_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat: sym=%h sv=%b last=%b done=%b err=%0d",
                                 i_sym, i_sym_valid, i_run_last, i_done_res, i_error);
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: expected sym=%h sv=%b last=%b done=%b ",
                                      "err=%0d, got sym=%h sv=%b last=%b done=%b err=%0d"},
                                     want.sym, want.sym_valid, want.run_last,
                                     want.done_res, want.error, i_sym, i_sym_valid,
                                     i_run_last, i_done_res, i_error);
                    end
                end
            end
        end
        queued = decoded_q.size();
    end

endmodule

[tb/sv/huffman_stream_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// huffman_stream_decoder_unit_tb
// Feeds one compressed stream (random tree, count, code bits) through the
// decoder under random bursts and output stalls; the checker judges results.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;

    // Kinds of stream that one run can carry; reset happens only once, so
    // each run picks one of them.
    typedef enum int {
        STREAM_MULTI,
        STREAM_SINGLE,
        STREAM_ZERO_COUNT,
        STREAM_OVERFLOW
    } t_stream;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic       i_op;
    logic [7:0] i_in_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_sym;
    logic       o_sym_valid;
    logic       o_run_last;
    logic       o_done_res;
    logic [1:0] o_error;
    int         fail_count;
    int         pending;

    logic [8:0] stream_q[$];   // {op, byte} per input beat
    bit         hdr_bits[$];
    int         sent;
    int         idle_cycles;

    huffman_stream_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sym       (o_sym),
        .o_sym_valid (o_sym_valid),
        .o_run_last  (o_run_last),
        .o_done_res  (o_done_res),
        .o_error     (o_error)
    );

    huffman_stream_decoder_unit_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_in_byte    (i_in_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sym        (o_sym),
        .i_sym_valid  (o_sym_valid),
        .i_run_last   (o_run_last),
        .i_done_res   (o_done_res),
        .i_error      (o_error),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Append a byte beat, now and then preceded by a stray pull that the
    // block must ignore.
    task automatic push_byte(logic [7:0] b, bit with_noise);
        if (with_noise && $urandom_range(0, 9) == 0)
            stream_q.push_back({1'b1, 8'($urandom)});
        stream_q.push_back({1'b0, b});
    endtask

    // Pack header bits MSB first; pad the last byte with random bits.
    task automatic flush_header();
        logic [7:0] b;
        while (hdr_bits.size() > 0) begin
            b = 8'($urandom);
            for (int i = 7; i >= 0 && hdr_bits.size() > 0; i--)
                b[i] = hdr_bits.pop_front();
            push_byte(b, 1'b1);
        end
    endtask

    task automatic add_leaf(logic [7:0] s);
        hdr_bits.push_back(1'b1);
        for (int i = 7; i >= 0; i--) hdr_bits.push_back(s[i]);
    endtask

    task automatic push_count(logic [31:0] c);
        for (int i = 0; i < 4; i++) push_byte(c[8*i +: 8], 1'b1);
    endtask

    // Build the whole input stream of this run.
    task automatic build_stream();
        t_stream    kind;
        int         roll, open_slots, internals, max_int, nbytes;
        logic [31:0] cnt;
        logic [7:0] s;
        roll = $urandom_range(0, 9);
        kind = (roll == 0) ? STREAM_OVERFLOW : (roll == 1) ? STREAM_SINGLE :
               (roll == 2) ? STREAM_ZERO_COUNT : STREAM_MULTI;
        // pull before anything arrives: ignored in the header phase
        stream_q.push_back({1'b1, 8'hFF});
        case (kind)
            STREAM_OVERFLOW: begin
                // all internal nodes: the stack runs past its depth
                for (int i = 0; i < 34; i++) push_byte(8'h00, 1'b1);
                // keep sending: every later beat reports the tree error
                for (int i = 0; i < 170; i++)
                    stream_q.push_back({1'($urandom), 8'($urandom)});
            end
            STREAM_SINGLE: begin
                add_leaf(8'($urandom));
                flush_header();
                cnt = $urandom_range(150, 200);
                push_count(cnt);
                for (int i = 0; i < cnt; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        stream_q.push_back({1'b0, 8'($urandom)});
                    stream_q.push_back({1'b1, 8'($urandom)});
                end
            end
            default: begin
                // pre-order tree; random symbols, some 00 leaves and FF for the last leaf
                max_int    = $urandom_range(1, 30);
                open_slots = 1;
                internals  = 0;
                while (open_slots > 0) begin
                    if (internals == 0 ||
                        (internals < max_int && $urandom_range(0, 1) == 1)) begin
                        hdr_bits.push_back(1'b0);
                        internals++;
                        open_slots++;
                    end else begin
                        s = (internals + open_slots == max_int + 1) ? 8'h00 : 8'($urandom);
                        if (open_slots == 1) s = 8'hFF;
                        add_leaf(s);
                        open_slots--;
                    end
                end
                flush_header();
                nbytes = $urandom_range(170, 190);
                cnt = (kind == STREAM_ZERO_COUNT) ? 32'd0 :
                      32'(nbytes * 8 - $urandom_range(0, 7));
                push_count(cnt);
                for (int i = 0; i < nbytes; i++) push_byte(8'($urandom), 1'b1);
            end
        endcase
        // beats after the end: after-done or tree-error status
        for (int i = 0; i < 5; i++) stream_q.push_back({1'($urandom), 8'($urandom)});
    endtask

    // Sender: bursts of random length with random gaps between them.
    initial begin
        int burst, gap;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_op       = 1'b0;
        i_in_byte  = '0;
        sent       = 0;
        burst      = 0;
        gap        = 0;
        build_stream();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_in_valid && o_in_ready) sent++;
            if (i_in_valid && !o_in_ready) begin
                // hold the beat until it is taken
            end else if (sent >= stream_q.size()) begin
                i_in_valid <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                {i_op, i_in_byte} <= stream_q[sent];
                if (burst > 0) begin
                    burst--;
                end else begin
                    burst = $urandom_range(1, 20);
                    gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Receiver: the stall pattern is redrawn at random times.
    initial begin
        int seg, mode;
        i_out_ready = 1'b0;
        seg = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (seg == 0) begin
                seg  = $urandom_range(20, 100);
                mode = $urandom_range(0, 2);
            end
            seg--;
            case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("huffman_stream_decoder_unit_tb failed");
                $finish;
            end
        end
    end

    // Verdict: wait for all stimulus and results, then drain a little longer.
    // Sample between edges so the counters of this edge are settled.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (sent >= stream_q.size() && pending == 0) break;
        end
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("huffman_stream_decoder_unit_tb passed");
        else
            $display("huffman_stream_decoder_unit_tb failed");
        $finish;
    end

endmodule
